// ===== hdl/mfmr_pkg.sv =====
// Shared types and constants for the multi-frame message reassembler.
`timescale 1ns / 1ps
package mfmr_pkg;

  localparam int MSG_MAX     = 32;
  localparam int ADDR_W      = $clog2(MSG_MAX);
  localparam int CNT_W       = $clog2(MSG_MAX + 1);
  localparam int FRAME_BYTES = 7;
  localparam int FF_BYTES    = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  SID_RESET     = 8'd39;

  localparam logic [3:0] FT_FIRST  = 4'd1;
  localparam logic [3:0] FT_CONSEC = 4'd2;
  localparam logic [3:0] FT_FLOW   = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CF_TIMEOUT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_SID = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_FC   = 2'd0,
    KIND_NRC  = 2'd1,
    KIND_BYTE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_LEN  = 2'd0,
    ERR_SEQ  = 2'd1,
    ERR_TIME = 2'd2,
    ERR_SVC  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STORE,
    S_RESP,
    S_READ,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  err_sid;
    err_e        err_code;
    logic [7:0]  msg_byte;
    logic [4:0]  msg_index;
    logic [5:0]  msg_length;
    logic        last;
  } out_t;

  // Write side of the message store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

// ===== hdl/multi_frame_message_reassembler_top.sv =====
// Top level: frame decode, serial byte store and message delivery.
// A frame is decoded, then its bytes are stored one at a time (up to 7 for a consecutive
// frame, 6 for a first frame), then a closing step follows and its result is posted.
// A completed message is delivered byte by byte, each a store read then an emit.
// Frames are taken one at a time; a new one is accepted after the last result
// of the previous frame sits in the output register.
// Reset (async, active low) clears control state and loads register defaults.
`timescale 1ns / 1ps
module multi_frame_message_reassembler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfmr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mfmr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mfmr_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mfmr_pkg::out_t                 out_data_o
);
  import mfmr_pkg::*;

  state_e state_q, state_d;

  logic [15:0] cf_timeout_q;
  logic [7:0]  service_sid_q;

  logic [8*FRAME_BYTES-1:0] shift_q, shift_d;
  logic [7:0]  ctl_q, ctl_d;
  logic [31:0] now_q, now_d;
  logic        receiving_q, receiving_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] recv_q, recv_d;
  logic [3:0]  seq_q, seq_d;
  logic [31:0] last_ms_q, last_ms_d;
  logic [7:0]  first_q, first_d;
  logic        ff_mode_q, ff_mode_d;
  logic [2:0]  k_q, k_d;
  logic [ADDR_W-1:0] rd_q, rd_d;
  out_t        resp_q, resp_d;
  out_t        out_q, out_d;
  logic        out_valid_q, out_valid_d;

  store_wr_t   wr;
  logic [7:0]  rdata;

  logic        accept, out_free, timed_out, store_ok, len_bad, emit_last;
  logic [31:0] gap;
  logic [3:0]  ftype;
  logic [7:0]  head;
  out_t        nrc_base;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign gap       = now_q - last_ms_q;
  assign timed_out = receiving_q && (gap > {16'd0, cf_timeout_q});
  assign ftype     = ctl_q[7:4];
  assign head      = shift_q[8*FRAME_BYTES-1 -: 8];
  assign len_bad   = (head == 8'd0) || (32'(head) > MSG_MAX);
  assign store_ok  = ff_mode_q ? (k_q < 3'(FF_BYTES))
                               : ((k_q < 3'(FRAME_BYTES)) && (recv_q < total_q));
  assign emit_last = (CNT_W'(rd_q) + CNT_W'(1)) == total_q;

  always_comb begin
    nrc_base          = '0;
    nrc_base.kind     = KIND_NRC;
    nrc_base.last     = 1'b1;
  end

  mfmr_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (timed_out) begin
          state_d = S_RESP;
        end else begin
          case (ftype)
            FT_FIRST:  state_d = len_bad ? S_RESP : S_STORE;
            FT_CONSEC: state_d = (!receiving_q || ctl_q[3:0] != seq_q) ? S_RESP : S_STORE;
            FT_FLOW:   state_d = S_IDLE;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_STORE: begin
        if (!store_ok) begin
          if (ff_mode_q) begin
            state_d = S_RESP;
          end else if (recv_q >= total_q) begin
            state_d = (first_q != service_sid_q) ? S_RESP : S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_READ: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = emit_last ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    shift_d     = shift_q;
    ctl_d       = ctl_q;
    now_d       = now_q;
    receiving_d = receiving_q;
    total_d     = total_q;
    recv_d      = recv_q;
    seq_d       = seq_q;
    last_ms_d   = last_ms_q;
    first_d     = first_q;
    ff_mode_d   = ff_mode_q;
    k_d         = k_q;
    rd_d        = rd_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr          = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_d   = in_data_i.byte0;
          now_d   = in_data_i.now_ms;
          shift_d = {in_data_i.byte1, in_data_i.byte2, in_data_i.byte3, in_data_i.byte4,
                     in_data_i.byte5, in_data_i.byte6, in_data_i.byte7};
        end
      end
      S_DECODE: begin
        k_d = '0;
        if (timed_out) begin
          resp_d          = nrc_base;
          resp_d.err_sid  = first_q;
          resp_d.err_code = ERR_TIME;
          receiving_d = 1'b0;
          total_d     = '0;
          recv_d      = '0;
          seq_d       = '0;
          last_ms_d   = '0;
        end else begin
          case (ftype)
            FT_FIRST: begin
              receiving_d = 1'b0;
              total_d     = '0;
              recv_d      = '0;
              seq_d       = '0;
              last_ms_d   = '0;
              if (len_bad) begin
                resp_d          = nrc_base;
                resp_d.err_sid  = shift_q[8*FRAME_BYTES-9 -: 8];
                resp_d.err_code = ERR_LEN;
              end else begin
                receiving_d = 1'b1;
                total_d     = CNT_W'(head);
                seq_d       = 4'd1;
                last_ms_d   = now_q;
                first_d     = shift_q[8*FRAME_BYTES-9 -: 8];
                ff_mode_d   = 1'b1;
                // drop the length byte; message bytes follow
                shift_d     = shift_q << 8;
              end
            end
            FT_CONSEC: begin
              if (!receiving_q) begin
                resp_d          = nrc_base;
                resp_d.err_sid  = service_sid_q;
                resp_d.err_code = ERR_SEQ;
              end else if (ctl_q[3:0] != seq_q) begin
                resp_d          = nrc_base;
                resp_d.err_sid  = first_q;
                resp_d.err_code = ERR_SEQ;
                receiving_d = 1'b0;
                total_d     = '0;
                recv_d      = '0;
                seq_d       = '0;
                last_ms_d   = '0;
              end else begin
                seq_d     = seq_q + 4'd1;
                last_ms_d = now_q;
                ff_mode_d = 1'b0;
              end
            end
            FT_FLOW: begin
            end
            default: begin
              resp_d          = nrc_base;
              resp_d.err_sid  = head;
              resp_d.err_code = ERR_LEN;
            end
          endcase
        end
      end
      S_STORE: begin
        if (store_ok) begin
          wr.we   = 1'b1;
          wr.addr = recv_q[ADDR_W-1:0];
          wr.data = head;
          recv_d  = recv_q + CNT_W'(1);
          k_d     = k_q + 3'd1;
          shift_d = shift_q << 8;
        end else if (ff_mode_q) begin
          resp_d      = '0;
          resp_d.kind = KIND_FC;
          resp_d.last = 1'b1;
        end else if (recv_q >= total_q) begin
          rd_d = '0;
          if (first_q != service_sid_q) begin
            resp_d          = nrc_base;
            resp_d.err_sid  = first_q;
            resp_d.err_code = ERR_SVC;
            receiving_d = 1'b0;
            total_d     = '0;
            recv_d      = '0;
            seq_d       = '0;
            last_ms_d   = '0;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = resp_q;
          out_valid_d = 1'b1;
        end
      end
      S_READ: begin
      end
      S_EMIT: begin
        if (out_free) begin
          out_d            = '0;
          out_d.kind       = KIND_BYTE;
          out_d.msg_byte   = rdata;
          out_d.msg_index  = 5'(rd_q);
          out_d.msg_length = 6'(total_q);
          out_d.last       = emit_last;
          out_valid_d      = 1'b1;
          rd_d             = rd_q + ADDR_W'(1);
          if (emit_last) begin
            receiving_d = 1'b0;
            total_d     = '0;
            recv_d      = '0;
            seq_d       = '0;
            last_ms_d   = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cf_timeout_q  <= TIMEOUT_RESET;
      service_sid_q <= SID_RESET;
      receiving_q   <= 1'b0;
      total_q       <= '0;
      recv_q        <= '0;
      seq_q         <= '0;
      last_ms_q     <= '0;
      ff_mode_q     <= 1'b0;
      k_q           <= '0;
      rd_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      receiving_q <= receiving_d;
      total_q     <= total_d;
      recv_q      <= recv_d;
      seq_q       <= seq_d;
      last_ms_q   <= last_ms_d;
      ff_mode_q   <= ff_mode_d;
      k_q         <= k_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CF_TIMEOUT:  cf_timeout_q  <= cfg_wdata_i[15:0];
          REG_SERVICE_SID: service_sid_q <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    ctl_q   <= ctl_d;
    now_q   <= now_d;
    first_q <= first_d;
    resp_q  <= resp_d;
    out_q   <= out_d;
  end

endmodule

// ===== hdl/mfmr_store.sv =====
// Message byte store: one write port, one registered read port.
`timescale 1ns / 1ps
module mfmr_store (
  input  logic                      clk_i,
  input  mfmr_pkg::store_wr_t       wr_i,
  input  logic [mfmr_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);
  import mfmr_pkg::*;

  logic [7:0] mem [MSG_MAX];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/multi_frame_message_reassembler_top_tb.sv =====
// Self-checking testbench for the multi-frame message reassembler top level.
`timescale 1ns / 1ps
module multi_frame_message_reassembler_top_tb;
  import mfmr_pkg::*;

  localparam int DRAIN_CYCLES   = 100;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int MAX_PRINTED    = 200;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;

  multi_frame_message_reassembler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state and register shadow
  logic [15:0] cfg_timeout_ms  = TIMEOUT_RESET;
  logic [7:0]  cfg_service_sid = SID_RESET;
  bit          rx_active       = 1'b0;
  logic [7:0]  msg_buf [MSG_MAX];
  int          msg_total       = 0;
  int          rx_count        = 0;
  logic [3:0]  seq_next        = '0;
  logic [31:0] last_ms         = '0;

  out_t        awaited[$];
  in_t         frame_q[$];
  int          pushed_count    = 0;
  int          accepted_count  = 0;
  int          response_count  = 0;
  int          mismatch_count  = 0;

  int          send_idle_pct   = 0;
  int          recv_idle_pct   = 0;
  logic        rx_hold_req     = 1'b0;
  int          rx_hold_left    = 0;
  logic [31:0] stim_ms         = '0;

  task automatic clear_message();
    rx_active = 1'b0;
    foreach (msg_buf[i]) msg_buf[i] = '0;
    msg_total = 0;
    rx_count  = 0;
    seq_next  = '0;
    last_ms   = '0;
  endtask

  task automatic queue_result(input kind_e kind_v, input logic [7:0] sid, input err_e code,
                              input logic [7:0] data, input int idx, input int len,
                              input bit is_last);
    out_t r;
    r            = '0;
    r.kind       = kind_v;
    r.err_sid    = sid;
    r.err_code   = code;
    r.msg_byte   = data;
    r.msg_index  = 5'(idx);
    r.msg_length = 6'(len);
    r.last       = is_last;
    awaited.push_back(r);
  endtask

  task automatic post_error(input logic [7:0] sid, input err_e code);
    queue_result(KIND_NRC, sid, code, 8'h00, 0, 0, 1'b1);
  endtask

  task automatic reassemble_frame(input in_t f);
    logic [31:0] gap;
    logic [7:0]  head;
    logic [7:0]  pay [FRAME_BYTES];
    gap = f.now_ms - last_ms;
    if (rx_active && gap > {16'h0, cfg_timeout_ms}) begin
      head = msg_buf[0];
      clear_message();
      post_error(head, ERR_TIME);
      return;
    end
    case (f.byte0[7:4])
      FT_FIRST: begin
        clear_message();
        if (f.byte1 == 0 || f.byte1 > MSG_MAX) begin
          post_error(f.byte2, ERR_LEN);
        end else begin
          msg_buf[0] = f.byte2;
          msg_buf[1] = f.byte3;
          msg_buf[2] = f.byte4;
          msg_buf[3] = f.byte5;
          msg_buf[4] = f.byte6;
          msg_buf[5] = f.byte7;
          msg_total  = f.byte1;
          rx_count   = FF_BYTES;
          seq_next   = 4'd1;
          rx_active  = 1'b1;
          last_ms    = f.now_ms;
          queue_result(KIND_FC, 8'h00, ERR_LEN, 8'h00, 0, 0, 1'b1);
        end
      end
      FT_CONSEC: begin
        if (!rx_active) begin
          post_error(cfg_service_sid, ERR_SEQ);
        end else if (f.byte0[3:0] != seq_next) begin
          head = msg_buf[0];
          clear_message();
          post_error(head, ERR_SEQ);
        end else begin
          pay = '{f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7};
          foreach (pay[k]) begin
            if (rx_count < msg_total) begin
              msg_buf[rx_count] = pay[k];
              rx_count++;
            end
          end
          seq_next = seq_next + 4'd1;
          last_ms  = f.now_ms;
          if (rx_count >= msg_total) begin
            head = msg_buf[0];
            if (head != cfg_service_sid) begin
              clear_message();
              post_error(head, ERR_SVC);
            end else begin
              for (int i = 0; i < msg_total; i++)
                queue_result(KIND_BYTE, 8'h00, ERR_LEN, msg_buf[i], i, msg_total,
                             i == msg_total - 1);
              clear_message();
            end
          end
        end
      end
      FT_FLOW: ;
      default: post_error(f.byte1, ERR_LEN);
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] MISMATCH response %0d: %s", $realtime, response_count, msg);
    mismatch_count++;
  endtask

  task automatic check_response(input out_t got);
    out_t  want;
    string diffs;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("no response expected, got %h", got));
      return;
    end
    want  = awaited.pop_front();
    diffs = "";
    if (got.kind !== want.kind)
      diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
    if (got.err_sid !== want.err_sid)
      diffs = {diffs, $sformatf(" err_sid %h/%h", got.err_sid, want.err_sid)};
    if (got.err_code !== want.err_code)
      diffs = {diffs, $sformatf(" err_code %0d/%0d", got.err_code, want.err_code)};
    if (got.msg_byte !== want.msg_byte)
      diffs = {diffs, $sformatf(" msg_byte %h/%h", got.msg_byte, want.msg_byte)};
    if (got.msg_index !== want.msg_index)
      diffs = {diffs, $sformatf(" msg_index %0d/%0d", got.msg_index, want.msg_index)};
    if (got.msg_length !== want.msg_length)
      diffs = {diffs, $sformatf(" msg_length %0d/%0d", got.msg_length, want.msg_length)};
    if (got.last !== want.last)
      diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
    if (diffs != "") report_mismatch({"got/exp", diffs});
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= frame_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      reassemble_frame(in_data_i);
      accepted_count++;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rx_hold_left <= 0;
    else if (rx_hold_req) rx_hold_left <= RX_HOLD_CYCLES;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_response(out_data_o);
      response_count++;
    end
  end

  // Stimulus helpers
  function automatic in_t rand_frame();
    in_t f;
    f = {$urandom, $urandom, $urandom};
    return f;
  endfunction

  // Mostly inside the timeout window, with exact-boundary and overrun cases
  function automatic logic [31:0] pick_gap();
    int unsigned r;
    logic [31:0] lim;
    r   = $urandom_range(99);
    lim = {16'h0, cfg_timeout_ms};
    if (r < 2) return lim + 32'd1 + ($urandom >> 1);
    if (r < 5) return lim + 32'd1 + $urandom_range(2000);
    if (r < 9) return lim;
    if (r < 14) return 32'd0;
    return $urandom_range(lim);
  endfunction

  task automatic add_frame(input in_t f, input logic [31:0] gap);
    stim_ms  = stim_ms + gap;
    f.now_ms = stim_ms;
    frame_q.push_back(f);
    pushed_count++;
  endtask

  task automatic add_first(input int len, input logic [7:0] head, input logic [31:0] gap);
    in_t f;
    f = rand_frame();
    f.byte0[7:4] = FT_FIRST;
    f.byte1      = 8'(len);
    f.byte2      = head;
    add_frame(f, gap);
  endtask

  task automatic add_consec(input logic [3:0] seq, input logic [31:0] gap);
    in_t f;
    f = rand_frame();
    f.byte0 = {FT_CONSEC, seq};
    add_frame(f, gap);
  endtask

  task automatic add_noise();
    in_t f;
    f = rand_frame();
    case ($urandom_range(3))
      0: f.byte0[7:4] = FT_FLOW;
      1: f.byte0[7:4] = FT_FIRST;
      default: ;
    endcase
    add_frame(f, pick_gap());
  endtask

  task automatic send_message(input int len, input logic [7:0] head, input int fault_pct);
    int n_cf;
    add_first(len, head, pick_gap());
    if (len == 0 || len > MSG_MAX) n_cf = $urandom_range(1);
    else if (len <= FF_BYTES) n_cf = 1;
    else n_cf = (len - FF_BYTES + FRAME_BYTES - 1) / FRAME_BYTES;
    for (int k = 1; k <= n_cf; k++) begin
      if ($urandom_range(99) < fault_pct) add_noise();
      if ($urandom_range(99) < fault_pct / 2) add_consec(4'($urandom_range(15)), pick_gap());
      else add_consec(4'(k), pick_gap());
    end
  endtask

  task automatic run_random(input int n_items);
    int          stop_at;
    int unsigned r;
    logic [7:0]  head;
    int          len;
    stop_at = pushed_count + n_items;
    while (pushed_count < stop_at) begin
      r = $urandom_range(99);
      if (r < 75) begin
        len  = ($urandom_range(99) < 85) ? $urandom_range(1, 14) : $urandom_range(15, MSG_MAX);
        head = ($urandom_range(99) < 85) ? cfg_service_sid : 8'($urandom);
        send_message(len, head, 12);
      end else if (r < 85) begin
        len = $urandom_range(1) ? 0 : $urandom_range(MSG_MAX + 1, 255);
        send_message(len, 8'($urandom), 0);
      end else begin
        add_noise();
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_CF_TIMEOUT) cfg_timeout_ms = data;
    else if (idx == REG_SERVICE_SID) cfg_service_sid = data[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Frames with no response may still be in flight, hence the extra cycles
  task automatic wait_drained();
    do @(posedge clk_i);
    while (accepted_count != pushed_count || awaited.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    in_t f;
    int  hold_base;
    stim_ms       = $urandom;
    send_idle_pct = 19;
    recv_idle_pct = 79;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray frames while idle
    add_consec(4'hF, 32'd0);
    f = rand_frame();
    f.byte0 = 8'h00;
    f.byte1 = 8'hFF;
    add_frame(f, 32'd0);
    f = rand_frame();
    f.byte0 = 8'hFF;
    f.byte1 = 8'h00;
    add_frame(f, 32'd0);
    f = rand_frame();
    f.byte0 = {FT_FLOW, 4'h0};
    add_frame(f, 32'd0);
    // first-frame length bounds
    add_first(0, 8'hFF, 32'd1);
    add_first(MSG_MAX + 1, 8'h00, 32'd1);
    add_first(255, 8'hA5, 32'd1);
    // short, longest, six-byte and unsupported-service messages
    send_message(1, cfg_service_sid, 0);
    send_message(MSG_MAX, cfg_service_sid, 0);
    send_message(FF_BYTES, cfg_service_sid, 0);
    send_message(8, ~cfg_service_sid, 0);
    // wrong sequence number
    add_first(10, cfg_service_sid, 32'd1);
    add_consec(4'd2, 32'd1);
    // gap one past the timeout
    add_first(10, cfg_service_sid, 32'd1);
    add_consec(4'd1, {16'h0, cfg_timeout_ms} + 32'd1);
    // gap exactly at the timeout, flow control mid-message
    add_first(9, cfg_service_sid, 32'd1);
    f = rand_frame();
    f.byte0 = {FT_FLOW, 4'h3};
    add_frame(f, 32'd0);
    add_consec(4'd1, {16'h0, cfg_timeout_ms});
    // new first frame drops the message in progress
    add_first(10, cfg_service_sid, 32'd1);
    add_first(3, cfg_service_sid, 32'd1);
    add_consec(4'd1, 32'd1);
    wait_drained();

    write_reg(REG_CF_TIMEOUT, 16'hFFFF);
    write_reg(REG_SERVICE_SID, {8'($urandom), 8'hFF});
    run_random(100);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 19;
    write_reg(REG_CF_TIMEOUT, 16'h0000);
    write_reg(REG_SERVICE_SID, {8'($urandom), 8'h00});
    run_random(90);
    wait_drained();

    write_reg(REG_CF_TIMEOUT, 16'($urandom));
    write_reg(REG_SERVICE_SID, 16'($urandom));
    hold_base = accepted_count;
    run_random(90);
    // long receiver stall while requests keep coming
    while (accepted_count < hold_base + 10) @(posedge clk_i);
    rx_hold_req <= 1'b1;
    @(posedge clk_i);
    rx_hold_req <= 1'b0;
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_CF_TIMEOUT, 16'd50);
    write_reg(REG_SERVICE_SID, 16'(SID_RESET));
    stim_ms = 32'hFFFF_FF00;  // tick wraps during this phase
    run_random(90);
    wait_drained();

    write_reg(REG_CF_TIMEOUT, TIMEOUT_RESET);
    write_reg(REG_SERVICE_SID, 16'($urandom));
    run_random(85);
    wait_drained();

    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
